FILE: src/assert_macros.svh
// Assertion macros for the checker file.
// Depends on nothing; take it in by include.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent assertion on a rising clock, disabled while the active-low reset is low.
`define ITP_ASSERT(name, clk, rst_n, prop) \
  name: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) \
    else $error("assertion failed");

// Same, for a property that must also hold while reset is asserted.
`define ITP_ASSERT_ALWAYS(name, clk, prop) \
  name: assert property (@(posedge clk) (prop)) \
    else $error("assertion failed");

`endif

FILE: src/itp_pkg.sv
// Types and constants for the interval timer pair with interrupt.
// Used by the timer, clock and top-level modules, by itp_in_if and by the bench; depends on nothing.
package itp_pkg;

  typedef enum logic [1:0] {
    FUNC_WRITE = 2'd0,
    FUNC_READ  = 2'd1,
    FUNC_TICK  = 2'd2,
    FUNC_NONE  = 2'd3
  } func_e;

  localparam logic [3:0] REG_PRA     = 4'd0;
  localparam logic [3:0] REG_PRB     = 4'd1;
  localparam logic [3:0] REG_TA_LO   = 4'd4;
  localparam logic [3:0] REG_TA_HI   = 4'd5;
  localparam logic [3:0] REG_TB_LO   = 4'd6;
  localparam logic [3:0] REG_TB_HI   = 4'd7;
  localparam logic [3:0] REG_TOD_10  = 4'd8;
  localparam logic [3:0] REG_TOD_SEC = 4'd9;
  localparam logic [3:0] REG_TOD_MIN = 4'd10;
  localparam logic [3:0] REG_TOD_HR  = 4'd11;
  localparam logic [3:0] REG_SDR     = 4'd12;
  localparam logic [3:0] REG_ICR     = 4'd13;
  localparam logic [3:0] REG_CRA     = 4'd14;
  localparam logic [3:0] REG_CRB     = 4'd15;

  localparam int CTRL_START   = 0;
  localparam int CTRL_ONESHOT = 3;
  localparam int CTRL_LOAD    = 4;
  localparam int ICR_SET      = 7;
  localparam int ICR_IR       = 7;

  localparam logic [7:0] MODE_MASK_A  = 8'h20;
  localparam logic [7:0] MODE_MASK_B  = 8'h60;
  localparam logic [7:0] PORT_RESET   = 8'hFF;
  localparam logic [15:0] TOD_RELOAD_RESET = 16'd4410;

  localparam logic [7:0] TOD_TENTHS_LIM = 8'd10;
  localparam logic [7:0] TOD_SEC_LIM    = 8'd60;
  localparam logic [7:0] TOD_MIN_LIM    = 8'd60;
  localparam logic [4:0] TOD_HR_LIM     = 5'd12;

  typedef struct packed {
    func_e       func;
    logic [3:0]  reg_addr;
    logic [7:0]  write_data;
    logic [15:0] elapsed_cycles;
  } in_item_t;

  typedef struct packed {
    logic        wr_lo;
    logic        wr_hi;
    logic        wr_ctrl;
    logic        tick;
    logic [7:0]  data;
    logic [15:0] elapsed;
  } timer_cmd_t;

  typedef struct packed {
    logic        wr_en;
    logic [1:0]  wr_idx;
    logic [7:0]  data;
    logic        tick;
  } tod_cmd_t;

endpackage

FILE: src/itp_if.sv
// Handshake channels of the timer block: input items, result items, config writes.
// Depends on itp_pkg.
interface itp_in_if;
  import itp_pkg::*;
  logic        valid;
  logic        ready;
  logic [1:0]  func;
  logic [3:0]  reg_addr;
  logic [7:0]  write_data;
  logic [15:0] elapsed_cycles;
  modport source (output valid, func, reg_addr, write_data, elapsed_cycles, input ready);
  modport sink   (input valid, func, reg_addr, write_data, elapsed_cycles, output ready);
endinterface

interface itp_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] read_data;
  logic       irq_request;
  modport source (output valid, read_data, irq_request, input ready);
  modport sink   (input valid, read_data, irq_request, output ready);
endinterface

interface itp_cfg_if;
  logic        valid;
  logic        ready;
  logic [15:0] tod_tick_reload;
  modport source (output valid, tod_tick_reload, input ready);
  modport sink   (input valid, tod_tick_reload, output ready);
endinterface

FILE: src/itp_timer.sv
// One 16-bit interval timer: latch, down counter and control byte.
// Depends on itp_pkg; commands come decoded from the top level.
module itp_timer import itp_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  timer_cmd_t  cmd_i,
  input  logic [7:0]  mode_mask_i,
  output logic [15:0] count_o,
  output logic [7:0]  control_o,
  output logic        underflow_o
);

  logic [15:0] latch_q, latch_d, count_q, count_d;
  logic [7:0]  ctrl_q, ctrl_d;
  logic        running, force_ld, expired;

  assign force_ld    = ctrl_q[CTRL_LOAD];
  assign running     = (ctrl_q & (mode_mask_i | 8'h01)) == 8'h01;
  assign expired     = count_q <= cmd_i.elapsed;
  assign underflow_o = cmd_i.tick && !force_ld && running && expired;

  always_comb begin
    latch_d = latch_q;
    count_d = count_q;
    ctrl_d  = ctrl_q;
    if (cmd_i.wr_lo) latch_d[7:0]  = cmd_i.data;
    if (cmd_i.wr_hi) latch_d[15:8] = cmd_i.data;
    if (cmd_i.wr_ctrl) ctrl_d = cmd_i.data;
    if (cmd_i.tick) begin
      if (force_ld) begin
        count_d = latch_q;
      end else if (running) begin
        count_d = expired ? latch_q : count_q - cmd_i.elapsed;
      end
      if (underflow_o && ctrl_q[CTRL_ONESHOT]) ctrl_d[CTRL_START] = 1'b0;
      ctrl_d[CTRL_LOAD] = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      latch_q <= '0;
      count_q <= '0;
      ctrl_q  <= '0;
    end else begin
      latch_q <= latch_d;
      count_q <= count_d;
      ctrl_q  <= ctrl_d;
    end
  end

  assign count_o   = count_q;
  assign control_o = ctrl_q;

endmodule

FILE: src/itp_tod.sv
// Binary time-of-day clock: tenths, seconds, minutes, 12-hour hours with PM bit.
// Depends on itp_pkg; prescaled by the tick count per tenth.
module itp_tod import itp_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  tod_cmd_t    cmd_i,
  input  logic [15:0] reload_i,
  output logic [7:0]  fields_o [4]
);

  logic [7:0]  fld_q [4];
  logic [7:0]  fld_d [4];
  logic [15:0] pre_q, pre_d;
  logic [7:0]  t0, t1, t2, hr;
  logic [4:0]  hr_lo;

  always_comb begin
    fld_d = fld_q;
    pre_d = pre_q;
    t0    = fld_q[0] + 8'd1;
    t1    = fld_q[1] + 8'd1;
    t2    = fld_q[2] + 8'd1;
    hr_lo = fld_q[3][4:0] + 5'd1;
    hr    = {fld_q[3][7:5], hr_lo};
    if (hr_lo >= TOD_HR_LIM) hr = {~fld_q[3][7], fld_q[3][6:5], 5'd0};
    if (cmd_i.wr_en) fld_d[cmd_i.wr_idx] = cmd_i.data;
    if (cmd_i.tick) begin
      if (pre_q <= 16'd1) begin
        pre_d = reload_i;
        if (t0 < TOD_TENTHS_LIM) begin
          fld_d[0] = t0;
        end else begin
          fld_d[0] = '0;
          if (t1 < TOD_SEC_LIM) begin
            fld_d[1] = t1;
          end else begin
            fld_d[1] = '0;
            if (t2 < TOD_MIN_LIM) begin
              fld_d[2] = t2;
            end else begin
              fld_d[2] = '0;
              fld_d[3] = hr;
            end
          end
        end
      end else begin
        pre_d = pre_q - 16'd1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fld_q <= '{default: '0};
      pre_q <= '0;
    end else begin
      fld_q <= fld_d;
      pre_q <= pre_d;
    end
  end

  assign fields_o = fld_q;

endmodule

FILE: src/interval_timer_pair_with_irq.sv
// Interval timer pair with interrupt control and time-of-day clock. One item
// (register write, register read or tick) is accepted per cycle, and
// back-pressure on the result side only stalls once the input register and
// the result register are both full. Each item passes through the input
// register and then the result register. All register state but the tick
// reload value updates in the cycle an item moves from the one to the other.
module interval_timer_pair_with_irq import itp_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  itp_cfg_if.sink   cfg_i,
  itp_in_if.sink    in_i,
  itp_out_if.source out_o
);

  in_item_t    item_q;
  logic        s1_valid_q, s1_valid_d;
  logic        out_valid_q, out_valid_d;
  logic [7:0]  rdata_q, rdata_d;
  logic        irq_q, irq_d;
  logic        out_take, proc, wr, rd, tick;

  logic [15:0] tod_reload_q;
  logic [7:0]  port_a_q, port_a_d, port_b_q, port_b_d, sdr_q, sdr_d;
  logic [4:0]  mask_q, mask_d;
  logic [7:0]  flags_q, flags_d;

  timer_cmd_t  cmd_a, cmd_b;
  tod_cmd_t    cmd_tod;
  logic [15:0] count_a, count_b;
  logic [7:0]  ctrl_a, ctrl_b;
  logic        uf_a, uf_b;
  logic [7:0]  tod_f [4];

  assign out_take = !out_valid_q || out_o.ready;
  assign proc     = s1_valid_q && out_take;
  assign in_i.ready  = !s1_valid_q || out_take;
  assign cfg_i.ready = 1'b1;

  assign wr   = proc && item_q.func == FUNC_WRITE;
  assign rd   = proc && item_q.func == FUNC_READ;
  assign tick = proc && item_q.func == FUNC_TICK;

  always_comb begin
    cmd_a         = '0;
    cmd_a.data    = item_q.write_data;
    cmd_a.elapsed = item_q.elapsed_cycles;
    cmd_b         = cmd_a;
    cmd_a.wr_lo   = wr && item_q.reg_addr == REG_TA_LO;
    cmd_a.wr_hi   = wr && item_q.reg_addr == REG_TA_HI;
    cmd_a.wr_ctrl = wr && item_q.reg_addr == REG_CRA;
    cmd_a.tick    = tick;
    cmd_b.wr_lo   = wr && item_q.reg_addr == REG_TB_LO;
    cmd_b.wr_hi   = wr && item_q.reg_addr == REG_TB_HI;
    cmd_b.wr_ctrl = wr && item_q.reg_addr == REG_CRB;
    cmd_b.tick    = tick;
    cmd_tod.wr_en  = wr && item_q.reg_addr[3:2] == REG_TOD_10[3:2];
    cmd_tod.wr_idx = item_q.reg_addr[1:0];
    cmd_tod.data   = item_q.write_data;
    cmd_tod.tick   = tick;
  end

  itp_timer u_timer_a (
    .clk_i, .rst_ni, .cmd_i(cmd_a), .mode_mask_i(MODE_MASK_A),
    .count_o(count_a), .control_o(ctrl_a), .underflow_o(uf_a)
  );

  itp_timer u_timer_b (
    .clk_i, .rst_ni, .cmd_i(cmd_b), .mode_mask_i(MODE_MASK_B),
    .count_o(count_b), .control_o(ctrl_b), .underflow_o(uf_b)
  );

  itp_tod u_tod (
    .clk_i, .rst_ni, .cmd_i(cmd_tod), .reload_i(tod_reload_q), .fields_o(tod_f)
  );

  always_comb begin
    port_a_d = port_a_q;
    port_b_d = port_b_q;
    sdr_d    = sdr_q;
    mask_d   = mask_q;
    flags_d  = flags_q;
    rdata_d  = '0;
    irq_d    = 1'b0;
    if (wr) begin
      case (item_q.reg_addr)
        REG_PRA: port_a_d = item_q.write_data;
        REG_PRB: port_b_d = item_q.write_data;
        REG_SDR: sdr_d    = item_q.write_data;
        REG_ICR: begin
          if (item_q.write_data[ICR_SET]) mask_d = mask_q | item_q.write_data[4:0];
          else mask_d = mask_q & ~item_q.write_data[4:0];
        end
        default: ;
      endcase
    end
    if (rd) begin
      case (item_q.reg_addr)
        REG_PRA:     rdata_d = port_a_q;
        REG_PRB:     rdata_d = port_b_q;
        REG_TA_LO:   rdata_d = count_a[7:0];
        REG_TA_HI:   rdata_d = count_a[15:8];
        REG_TB_LO:   rdata_d = count_b[7:0];
        REG_TB_HI:   rdata_d = count_b[15:8];
        REG_TOD_10:  rdata_d = tod_f[0];
        REG_TOD_SEC: rdata_d = tod_f[1];
        REG_TOD_MIN: rdata_d = tod_f[2];
        REG_TOD_HR:  rdata_d = tod_f[3];
        REG_SDR:     rdata_d = sdr_q;
        REG_ICR: begin
          rdata_d = flags_q;
          flags_d = '0;
        end
        REG_CRA: rdata_d = ctrl_a & ~(8'd1 << CTRL_LOAD);
        REG_CRB: rdata_d = ctrl_b & ~(8'd1 << CTRL_LOAD);
        default: rdata_d = '0;
      endcase
    end
    if (tick) begin
      irq_d   = (uf_a && mask_q[0]) || (uf_b && mask_q[1]);
      flags_d = flags_q | {6'd0, uf_b, uf_a};
      if (irq_d) flags_d[ICR_IR] = 1'b1;
    end
  end

  always_comb begin
    s1_valid_d = s1_valid_q;
    if (in_i.valid && in_i.ready) s1_valid_d = 1'b1;
    else if (proc) s1_valid_d = 1'b0;
    out_valid_d = out_valid_q;
    if (proc) out_valid_d = 1'b1;
    else if (out_o.ready) out_valid_d = 1'b0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q   <= 1'b0;
      out_valid_q  <= 1'b0;
      tod_reload_q <= TOD_RELOAD_RESET;
      port_a_q     <= PORT_RESET;
      port_b_q     <= PORT_RESET;
      sdr_q        <= '0;
      mask_q       <= '0;
      flags_q      <= '0;
    end else begin
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
      if (cfg_i.valid) tod_reload_q <= cfg_i.tod_tick_reload;
      port_a_q <= port_a_d;
      port_b_q <= port_b_d;
      sdr_q    <= sdr_d;
      mask_q   <= mask_d;
      flags_q  <= flags_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.valid && in_i.ready) begin
      item_q.func           <= func_e'(in_i.func);
      item_q.reg_addr       <= in_i.reg_addr;
      item_q.write_data     <= in_i.write_data;
      item_q.elapsed_cycles <= in_i.elapsed_cycles;
    end
    if (proc) begin
      rdata_q <= rdata_d;
      irq_q   <= irq_d;
    end
  end

  assign out_o.valid       = out_valid_q;
  assign out_o.read_data   = rdata_q;
  assign out_o.irq_request = irq_q;

endmodule

FILE: src/itp_checker.sv
// Port-level checks of the timer block, bound to the top level.
// Depends on assert_macros.svh.
`include "assert_macros.svh"

module itp_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_valid_i,
  input logic       in_ready_i,
  input logic       out_valid_i,
  input logic       out_ready_i,
  input logic [7:0] read_data_i,
  input logic       irq_request_i,
  input logic       cfg_valid_i,
  input logic       cfg_ready_i
);

  `ITP_ASSERT(a_out_hold, clk_i, rst_ni, out_valid_i && !out_ready_i |=> out_valid_i)
  `ITP_ASSERT(a_ready_when_empty, clk_i, rst_ni, !out_valid_i |-> in_ready_i)
  `ITP_ASSERT(a_latency, clk_i, rst_ni, $rose(out_valid_i) |-> $past(in_valid_i && in_ready_i, 2))
  `ITP_ASSERT(a_irq_no_data, clk_i, rst_ni, out_valid_i && irq_request_i |-> read_data_i == 8'd0)
  `ITP_ASSERT(a_cfg_ready, clk_i, rst_ni, cfg_valid_i |-> cfg_ready_i)

endmodule

bind interval_timer_pair_with_irq itp_checker u_itp_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .in_valid_i    (in_i.valid),
  .in_ready_i    (in_i.ready),
  .out_valid_i   (out_o.valid),
  .out_ready_i   (out_o.ready),
  .read_data_i   (out_o.read_data),
  .irq_request_i (out_o.irq_request),
  .cfg_valid_i   (cfg_i.valid),
  .cfg_ready_i   (cfg_i.ready)
);

FILE: dv/tb_interval_timer_pair_with_irq.sv
// Self-checking bench for interval_timer_pair_with_irq: directed and random register
// accesses and ticks, each result checked against an in-bench model of the timer pair.
// Depends on itp_pkg, the itp_*_if interfaces and the block RTL.
module tb_interval_timer_pair_with_irq;
  import itp_pkg::*;

  localparam int CYCLE_LIMIT = 600000;
  localparam logic [7:0] FLAG_A = 8'h01;
  localparam logic [7:0] FLAG_B = 8'h02;

  typedef struct packed {
    logic [7:0] rd;
    logic       irq;
  } access_result_t;

  logic clk_i = 1'b0;
  logic rst_ni;

  itp_cfg_if cfg_if();
  itp_in_if  in_if();
  itp_out_if out_if();

  interval_timer_pair_with_irq u_dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .cfg_i (cfg_if),
    .in_i  (in_if),
    .out_o (out_if)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // model state
  logic [15:0] tick_reload;
  logic [7:0]  pra, prb;
  logic [15:0] lat_a, lat_b, cnt_a, cnt_b;
  logic [7:0]  ctl_a, ctl_b;
  logic [4:0]  int_mask;
  logic [7:0]  int_flags;
  logic [7:0]  sdr;
  logic [7:0]  tod [4];
  logic [15:0] tod_prescale;

  in_item_t       items_to_send[$];
  access_result_t results_due[$];
  in_item_t       cur_item;
  int gap_left = 0;
  int calm_tx = 0;
  int calm_rx = 0;
  int stall_left = 0;
  int hold_left = 0;
  int results_seen = 0;
  int err_count = 0;
  int cycles = 0;

  function automatic logic step_counter(inout logic [15:0] cnt, input logic [15:0] lat,
                                        inout logic [7:0] ctl, input logic [7:0] mode_mask,
                                        input logic [7:0] flag, input logic [15:0] elapsed);
    int   t;
    logic hit;
    hit = 1'b0;
    if (ctl[CTRL_LOAD]) begin
      cnt = lat;
    end else if ((ctl & (mode_mask | 8'(1 << CTRL_START))) == 8'(1 << CTRL_START)) begin
      t = int'(cnt) - int'(elapsed);
      if (t <= 0) begin
        t = int'(lat);
        if (ctl[CTRL_ONESHOT]) ctl[CTRL_START] = 1'b0;
        int_flags = int_flags | flag;
        if ((int_mask & flag[4:0]) != 5'd0) begin
          int_flags[ICR_IR] = 1'b1;
          hit = 1'b1;
        end
      end
      cnt = t[15:0];
    end
    ctl[CTRL_LOAD] = 1'b0;
    return hit;
  endfunction

  function automatic void advance_tod();
    logic [7:0] hr;
    tod[0] = tod[0] + 8'd1;
    if (tod[0] < TOD_TENTHS_LIM) return;
    tod[0] = 8'd0;
    tod[1] = tod[1] + 8'd1;
    if (tod[1] < TOD_SEC_LIM) return;
    tod[1] = 8'd0;
    tod[2] = tod[2] + 8'd1;
    if (tod[2] < TOD_MIN_LIM) return;
    tod[2] = 8'd0;
    hr = tod[3];
    hr[4:0] = hr[4:0] + 5'd1;
    if (hr[4:0] >= TOD_HR_LIM) hr = {~hr[7], hr[6:5], 5'd0};
    tod[3] = hr;
  endfunction

  function automatic access_result_t apply_access(in_item_t it);
    access_result_t r;
    logic hit_a, hit_b;
    r = '0;
    case (it.func)
      FUNC_WRITE: begin
        case (it.reg_addr)
          REG_PRA:   pra = it.write_data;
          REG_PRB:   prb = it.write_data;
          REG_TA_LO: lat_a[7:0] = it.write_data;
          REG_TA_HI: lat_a[15:8] = it.write_data;
          REG_TB_LO: lat_b[7:0] = it.write_data;
          REG_TB_HI: lat_b[15:8] = it.write_data;
          REG_TOD_10, REG_TOD_SEC, REG_TOD_MIN, REG_TOD_HR: tod[it.reg_addr[1:0]] = it.write_data;
          REG_SDR:   sdr = it.write_data;
          REG_ICR: begin
            if (it.write_data[ICR_SET]) int_mask = int_mask | it.write_data[4:0];
            else int_mask = int_mask & ~it.write_data[4:0];
          end
          REG_CRA:   ctl_a = it.write_data;
          REG_CRB:   ctl_b = it.write_data;
          default: ;
        endcase
      end
      FUNC_READ: begin
        case (it.reg_addr)
          REG_PRA:   r.rd = pra;
          REG_PRB:   r.rd = prb;
          REG_TA_LO: r.rd = cnt_a[7:0];
          REG_TA_HI: r.rd = cnt_a[15:8];
          REG_TB_LO: r.rd = cnt_b[7:0];
          REG_TB_HI: r.rd = cnt_b[15:8];
          REG_TOD_10, REG_TOD_SEC, REG_TOD_MIN, REG_TOD_HR: r.rd = tod[it.reg_addr[1:0]];
          REG_SDR:   r.rd = sdr;
          REG_ICR: begin
            r.rd = int_flags;
            int_flags = 8'd0;
          end
          REG_CRA: begin
            r.rd = ctl_a;
            r.rd[CTRL_LOAD] = 1'b0;
          end
          REG_CRB: begin
            r.rd = ctl_b;
            r.rd[CTRL_LOAD] = 1'b0;
          end
          default: ;
        endcase
      end
      FUNC_TICK: begin
        hit_a = step_counter(cnt_a, lat_a, ctl_a, MODE_MASK_A, FLAG_A, it.elapsed_cycles);
        hit_b = step_counter(cnt_b, lat_b, ctl_b, MODE_MASK_B, FLAG_B, it.elapsed_cycles);
        r.irq = hit_a | hit_b;
        if (tod_prescale <= 16'd1) begin
          tod_prescale = tick_reload;
          advance_tod();
        end else begin
          tod_prescale = tod_prescale - 16'd1;
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  function automatic in_item_t mk(func_e f, logic [3:0] a, logic [7:0] d, logic [15:0] e);
    in_item_t it;
    it.func = f;
    it.reg_addr = a;
    it.write_data = d;
    it.elapsed_cycles = e;
    return it;
  endfunction

  function automatic int pause_len(inout int calm);
    int r;
    if (calm > 0) begin
      calm--;
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 3) begin
      calm = $urandom_range(20, 80);
      return 0;
    end
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(4, 40);
  endfunction

  function automatic in_item_t random_access();
    in_item_t it;
    int r, re;
    it = mk(FUNC_TICK, 4'($urandom), 8'($urandom), 16'($urandom));
    r = $urandom_range(0, 99);
    if (r < 40) begin
      re = $urandom_range(0, 99);
      if (re < 45) it.elapsed_cycles = 16'($urandom_range(0, 40));
      else if (re < 75) it.elapsed_cycles = 16'($urandom_range(0, 700));
      else if (re >= 95) it.elapsed_cycles = re[0] ? 16'hFFFF : 16'h0000;
    end else if (r < 65) begin
      it.func = FUNC_WRITE;
    end else if (r < 95) begin
      it.func = FUNC_READ;
    end else begin
      it.func = FUNC_NONE;
    end
    return it;
  endfunction

  // now and then armed counters and clock rollovers with random content, mostly noise
  task automatic queue_random(int n);
    int left, r;
    logic which;
    logic [7:0] d;
    left = n;
    while (left > 0) begin
      r = $urandom_range(0, 99);
      if (r < 8) begin
        which = 1'($urandom);
        d = 8'($urandom);
        d[6:5] = 2'b00;
        d[CTRL_START] = 1'b1;
        items_to_send.push_back(mk(FUNC_WRITE, which ? REG_TB_LO : REG_TA_LO,
                                   8'($urandom), 16'd0));
        items_to_send.push_back(mk(FUNC_WRITE, which ? REG_TB_HI : REG_TA_HI,
                                   ($urandom_range(0, 99) < 70) ? 8'd0 : 8'($urandom),
                                   16'd0));
        items_to_send.push_back(mk(FUNC_WRITE, which ? REG_CRB : REG_CRA, d, 16'd0));
        left -= 3;
      end else if (r < 10) begin
        items_to_send.push_back(mk(FUNC_WRITE, REG_TOD_HR, 8'($urandom), 16'd0));
        items_to_send.push_back(mk(FUNC_WRITE, REG_TOD_MIN, 8'd59, 16'd0));
        items_to_send.push_back(mk(FUNC_WRITE, REG_TOD_SEC, 8'd59, 16'd0));
        items_to_send.push_back(mk(FUNC_WRITE, REG_TOD_10, 8'd9, 16'd0));
        left -= 4;
      end else begin
        items_to_send.push_back(random_access());
        left--;
      end
    end
  endtask

  task automatic drain();
    while (items_to_send.size() != 0 || in_if.valid || results_due.size() != 0)
      @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic report_mismatch(string what, logic [7:0] got, logic [7:0] want);
    err_count++;
    $display("mismatch on %s at result %0d: got %02h, want %02h",
             what, results_seen, got, want);
  endtask

  // input side
  always @(posedge clk_i) begin : drive_in
    if (!rst_ni) begin
      in_if.valid <= 1'b0;
    end else begin
      if (in_if.valid && in_if.ready) results_due.push_back(apply_access(cur_item));
      if (!in_if.valid || in_if.ready) begin
        if (gap_left > 0 || items_to_send.size() == 0) begin
          if (gap_left > 0) gap_left--;
          in_if.valid <= 1'b0;
        end else begin
          cur_item = items_to_send.pop_front();
          gap_left = pause_len(calm_tx);
          in_if.valid          <= 1'b1;
          in_if.func           <= cur_item.func;
          in_if.reg_addr       <= cur_item.reg_addr;
          in_if.write_data     <= cur_item.write_data;
          in_if.elapsed_cycles <= cur_item.elapsed_cycles;
        end
      end
    end
  end

  // result side
  always @(posedge clk_i) begin : check_out
    access_result_t want;
    if (!rst_ni) begin
      out_if.ready <= 1'b0;
    end else begin
      if (out_if.valid && out_if.ready) begin
        if (results_due.size() == 0) begin
          report_mismatch("unexpected item", out_if.read_data, 8'd0);
        end else begin
          want = results_due.pop_front();
          if (out_if.read_data !== want.rd)
            report_mismatch("read_data", out_if.read_data, want.rd);
          if (out_if.irq_request !== want.irq)
            report_mismatch("irq_request", 8'(out_if.irq_request), 8'(want.irq));
        end
        results_seen++;
        stall_left = pause_len(calm_rx);
        if (results_seen % 600 == 200) hold_left = 400;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_if.ready <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        out_if.ready <= 1'b0;
      end else begin
        out_if.ready <= 1'b1;
      end
    end
  end

  always @(posedge clk_i) begin : watchdog
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  initial begin : run
    logic [15:0] reload_plan [6];
    reload_plan = '{16'd0, 16'd1, 16'hFFFF, 16'd2, 16'($urandom_range(1, 65535)), 16'd1};

    rst_ni = 1'b0;
    cfg_if.valid = 1'b0;
    cfg_if.tod_tick_reload = 16'd0;
    in_if.valid = 1'b0;
    in_if.func = FUNC_NONE;
    in_if.reg_addr = 4'd0;
    in_if.write_data = 8'd0;
    in_if.elapsed_cycles = 16'd0;
    out_if.ready = 1'b0;

    tick_reload = TOD_RELOAD_RESET;
    pra = PORT_RESET;
    prb = PORT_RESET;
    lat_a = '0; lat_b = '0; cnt_a = '0; cnt_b = '0;
    ctl_a = '0; ctl_b = '0;
    int_mask = '0; int_flags = '0; sdr = '0;
    foreach (tod[i]) tod[i] = '0;
    tod_prescale = '0;

    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // clock rollover on the first tick, force load, full-range underflow,
    // zero latch with one-shot, flag read and clear, unused accesses
    items_to_send.push_back(mk(FUNC_WRITE, REG_TOD_HR, 8'h8B, 16'd0));
    items_to_send.push_back(mk(FUNC_WRITE, REG_TOD_MIN, 8'd59, 16'd0));
    items_to_send.push_back(mk(FUNC_WRITE, REG_TOD_SEC, 8'd59, 16'd0));
    items_to_send.push_back(mk(FUNC_WRITE, REG_TOD_10, 8'd9, 16'd0));
    items_to_send.push_back(mk(FUNC_WRITE, REG_ICR, 8'h83, 16'd0));
    items_to_send.push_back(mk(FUNC_WRITE, REG_TA_LO, 8'hFF, 16'd0));
    items_to_send.push_back(mk(FUNC_WRITE, REG_TA_HI, 8'hFF, 16'd0));
    items_to_send.push_back(mk(FUNC_WRITE, REG_CRA, 8'h11, 16'd0));
    items_to_send.push_back(mk(FUNC_WRITE, REG_CRB, 8'h19, 16'd0));
    items_to_send.push_back(mk(FUNC_TICK, 4'd0, 8'd0, 16'd0));
    items_to_send.push_back(mk(FUNC_READ, REG_TOD_HR, 8'd0, 16'd0));
    items_to_send.push_back(mk(FUNC_READ, REG_TA_HI, 8'd0, 16'd0));
    items_to_send.push_back(mk(FUNC_TICK, 4'hF, 8'hFF, 16'hFFFF));
    items_to_send.push_back(mk(FUNC_READ, REG_ICR, 8'd0, 16'd0));
    items_to_send.push_back(mk(FUNC_READ, REG_ICR, 8'd0, 16'd0));
    items_to_send.push_back(mk(FUNC_READ, REG_CRB, 8'd0, 16'd0));
    items_to_send.push_back(mk(FUNC_READ, 4'd2, 8'd0, 16'd0));
    items_to_send.push_back(mk(FUNC_WRITE, 4'd3, 8'hFF, 16'd0));
    items_to_send.push_back(mk(FUNC_READ, REG_PRA, 8'd0, 16'd0));
    items_to_send.push_back(mk(FUNC_WRITE, REG_PRB, 8'h00, 16'd0));
    items_to_send.push_back(mk(FUNC_READ, REG_PRB, 8'd0, 16'd0));
    items_to_send.push_back(mk(FUNC_WRITE, REG_SDR, 8'hA5, 16'd0));
    items_to_send.push_back(mk(FUNC_READ, REG_SDR, 8'd0, 16'd0));
    items_to_send.push_back(mk(FUNC_NONE, 4'hF, 8'hFF, 16'hFFFF));
    items_to_send.push_back(mk(FUNC_WRITE, REG_ICR, 8'h1F, 16'd0));
    queue_random(250);

    for (int p = 1; p < 6; p++) begin
      drain();
      cfg_if.valid <= 1'b1;
      cfg_if.tod_tick_reload <= reload_plan[p];
      do @(posedge clk_i); while (!cfg_if.ready);
      cfg_if.valid <= 1'b0;
      tick_reload = reload_plan[p];
      queue_random(260);
    end

    drain();
    repeat (8) @(posedge clk_i);
    if (err_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

FILE: interval_timer_pair_with_irq.f
+incdir+src
src/itp_pkg.sv
src/itp_if.sv
src/itp_timer.sv
src/itp_tod.sv
src/interval_timer_pair_with_irq.sv
src/itp_checker.sv
dv/tb_interval_timer_pair_with_irq.sv
